/* rtl/shr_pkg.sv */
// shared types, constants and arithmetic helpers of the stereo hermite resampler
package shr_pkg;

  localparam int CH   = 2;
  localparam int SW   = 16;
  localparam int FW   = 16;
  localparam int WD   = 4;
  localparam int MAXO = 32;
  localparam int QD   = 4;
  localparam int NST  = 7;

  localparam int PW   = FW + 5;
  localparam int CW   = SW + 4;
  localparam int AW   = SW + 5;
  localparam int MW   = AW + FW + 1;
  localparam int QAW  = $clog2(QD);
  localparam int WAW  = $clog2(WD);
  localparam int HW   = $clog2(WD + 1);
  localparam int OCW  = $clog2(MAXO);

  localparam int CH_L = 0;
  localparam int CH_R = 1;

  typedef logic signed [SW-1:0] sample_t;
  typedef sample_t [CH-1:0]     frame_t;
  typedef frame_t [WD-1:0]      window_t;
  typedef logic [FW-1:0]        frac_t;
  typedef logic [PW-1:0]        pos_t;
  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [MW-1:0] prod_t;
  typedef logic signed [AW:0]   wide_t;

  localparam pos_t ONE_POS = pos_t'(1) << FW;
  localparam pos_t POS_MAX = '1;

  localparam wide_t SAT_HI = wide_t'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam wide_t SAT_LO = -SAT_HI - wide_t'(1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    STG_COEF,
    STG_MUL1,
    STG_ADD1,
    STG_MUL2,
    STG_ADD2,
    STG_MUL3,
    STG_OUT
  } stage_e;

  typedef struct packed {
    window_t win;
    frac_t   t;
    logic    last;
  } job_t;

  typedef struct packed {
    sample_t x1;
    coef_t   c1;
    coef_t   c2;
    prod_t   acc;
  } lane_t;

  typedef struct packed {
    lane_t [CH-1:0] lane;
    frac_t          t;
    logic           last;
  } stage_t;

  // product scaled down by the fraction width, round half up
  function automatic acc_t rnd_frac(prod_t p);
    prod_t s;
    s = p + (prod_t'(1) <<< (FW - 1));
    return acc_t'(s >>> FW);
  endfunction

  function automatic sample_t sat_sample(wide_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = sample_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = sample_t'(SAT_LO);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/shr_front.sv */
// front end: frame window, read position and issue of interpolation jobs
module shr_front import shr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t left_sample_i,
  input  sample_t right_sample_i,
  input  logic    cfg_we_i,
  input  pos_t    cfg_wdata_i,
  output logic    push_o,
  output job_t    job_o,
  input  logic    full_i
);

  state_e           state_q, state_d;
  window_t          win_q, win_d;
  pos_t             pos_q, pos_d;
  pos_t             step_q;
  logic [HW-1:0]    held_q, held_d;
  logic [OCW-1:0]   cnt_q, cnt_d;
  logic [PW:0]      pos_sum;
  pos_t             pos_nxt;
  logic             last;
  frame_t           in_frame;

  always_comb begin
    in_frame[CH_L] = left_sample_i;
    in_frame[CH_R] = right_sample_i;
    pos_sum = {1'b0, pos_q} + {1'b0, step_q};
    pos_nxt = pos_sum[PW] ? POS_MAX : pos_sum[PW-1:0];
    last = (cnt_q == OCW'(MAXO - 1)) || (pos_nxt[PW-1:FW] != (PW-FW)'(1));

    state_d    = state_q;
    win_d      = win_q;
    pos_d      = pos_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cnt_d = '0;
          if (held_q < HW'(WD)) begin
            win_d[held_q[WAW-1:0]] = in_frame;
            held_d = held_q + HW'(1);
            if (held_q == HW'(WD - 1)) begin
              state_d = ST_EMIT;
            end
          end else begin
            for (int i = 0; i < WD - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            win_d[WD-1] = in_frame;
            pos_d = (pos_q >= ONE_POS) ? pos_q - ONE_POS : '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (pos_q[PW-1:FW] != (PW-FW)'(1)) begin
          state_d = ST_IDLE;
        end else begin
          push_o = 1'b1;
          if (!full_i) begin
            pos_d = pos_nxt;
            cnt_d = cnt_q + OCW'(1);
            if (last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    job_o.win  = win_q;
    job_o.t    = pos_q[FW-1:0];
    job_o.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= '0;
      pos_q   <= ONE_POS;
      step_q  <= ONE_POS;
      held_q  <= HW'(1);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && held_q < HW'(WD - 1) |=> state_q == ST_IDLE)
    else $error("emit started before the window was full");

  a_emit_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> held_q == HW'(WD))
    else $error("emit with partial window");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && !full_i && job_o.last |=> state_q == ST_IDLE)
    else $error("run continued after last item");
`endif

endmodule

/* rtl/shr_queue.sv */
// short job queue between front end and interpolation pipeline
module shr_queue import shr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t           mem_q [QD];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (QAW+1)'(QD));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QD))
    else $error("queue count above depth");
`endif

endmodule

/* rtl/shr_back.sv */
// back end: pipelined catmull-rom evaluation per channel and output register
module shr_back import shr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    job_i,
  input  logic    empty_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sample_t left_out_o,
  output sample_t right_out_o,
  output logic    last_of_run_o
);

  stage_t         st_q [NST];
  stage_t         st_d [NST];
  logic [NST-1:0] vld_q, vld_d;
  logic           en;

  // twice the hermite coefficients, exact
  function automatic stage_t coef_stage(job_t j);
    stage_t s;
    coef_t  x0, x1, x2, x3, d;
    s      = '0;
    s.t    = j.t;
    s.last = j.last;
    for (int c = 0; c < CH; c++) begin
      x0 = coef_t'($signed(j.win[0][c]));
      x1 = coef_t'($signed(j.win[1][c]));
      x2 = coef_t'($signed(j.win[2][c]));
      x3 = coef_t'($signed(j.win[3][c]));
      d  = x1 - x2;
      s.lane[c].x1  = j.win[1][c];
      s.lane[c].c1  = x2 - x0;
      s.lane[c].c2  = (x0 <<< 1) - (x1 <<< 2) - x1 + (x2 <<< 2) - x3;
      s.lane[c].acc = prod_t'(x3 - x0 + (d <<< 1) + d);
    end
    return s;
  endfunction

  function automatic stage_t work_stage(stage_e op, stage_t s);
    stage_t r;
    acc_t   a;
    wide_t  h;
    wide_t  y;
    r = s;
    for (int c = 0; c < CH; c++) begin
      case (op)
        STG_MUL1, STG_MUL2, STG_MUL3: begin
          r.lane[c].acc = $signed(s.lane[c].acc[AW-1:0]) * $signed({1'b0, s.t});
        end
        STG_ADD1: begin
          r.lane[c].acc = prod_t'(rnd_frac(s.lane[c].acc) + acc_t'(s.lane[c].c2));
        end
        STG_ADD2: begin
          r.lane[c].acc = prod_t'(rnd_frac(s.lane[c].acc) + acc_t'(s.lane[c].c1));
        end
        STG_OUT: begin
          a = rnd_frac(s.lane[c].acc);
          h = ($signed({a[AW-1], a}) + $signed(wide_t'(1))) >>> 1;
          y = wide_t'(s.lane[c].x1) + h;
          r.lane[c].x1 = sat_sample(y);
        end
        default: begin
          r.lane[c] = s.lane[c];
        end
      endcase
    end
    return r;
  endfunction

  assign en    = !(vld_q[NST-1] && !out_ready_i);
  assign pop_o = en && !empty_i;

  always_comb begin
    st_d[int'(STG_COEF)]  = coef_stage(job_i);
    vld_d[int'(STG_COEF)] = !empty_i;
    for (int k = 1; k < NST; k++) begin
      st_d[k]  = work_stage(stage_e'(k), st_q[k-1]);
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o   = vld_q[NST-1];
  assign left_out_o    = st_q[NST-1].lane[CH_L].x1;
  assign right_out_o   = st_q[NST-1].lane[CH_R].x1;
  assign last_of_run_o = st_q[NST-1].last;

`ifndef NO_ASSERTIONS
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-1] && !out_ready_i |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  a_pop_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> vld_q[0])
    else $error("popped job lost at pipeline entry");
`endif

endmodule

/* rtl/stereo_hermite_resampler.sv */
// top level of the stereo cubic hermite sample-rate converter
//
// input channel: in_valid_i / in_ready_o with one stereo frame of signed
// q1.15 samples per item. output channel: out_valid_o / out_ready_i with
// interpolated left and right samples and last_of_run_o on the final item
// caused by one input frame. step_ratio is written through cfg_we_i and
// cfg_wdata_i (16 fraction bits) while the block is idle, a rule for the user
// that the block itself does not enforce. after reset the window holds one
// silent frame, the position is 1.0 and the step is 1.0; the first two
// frames give no result. a frame accepted while the window fills leaves the
// front end idle and ready; once the window is full, the issue sequencer
// pushes the results one after another (up to 32), waiting while the job
// queue is full, or passes once through its emit state when no result is
// due, and holds in_ready_o low until it is idle again. the results pass
// through the job queue and a seven-stage interpolation pipeline, one result
// per cycle when the receiver is ready. when it stalls, the pipeline holds,
// the four-entry job queue fills and the sequencer waits, in_ready_o low.
module stereo_hermite_resampler import shr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t left_sample_i,
  input  sample_t right_sample_i,
  input  logic    cfg_we_i,
  input  pos_t    cfg_wdata_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sample_t left_out_o,
  output sample_t right_out_o,
  output logic    last_of_run_o
);

  logic push, full, pop, empty;
  job_t push_job, pop_job;

  shr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push_o         (push),
    .job_o          (push_job),
    .full_i         (full)
  );

  shr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  shr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (pop_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* tb/tb_stereo_hermite_resampler.sv */
// self-checking testbench of the stereo cubic hermite resampler with a built-in predictor
module tb_stereo_hermite_resampler import shr_pkg::*;;

  localparam int SETTLE     = 24;
  localparam int MAX_CYCLES = 5000000;
  localparam int N_DIRECTED = 20;
  localparam int N_PHASES   = 10;
  localparam pos_t HALF_STEP = pos_t'(32768);
  localparam pos_t MIN_STEP  = pos_t'(2048);
  localparam pos_t MAX_STEP  = pos_t'(1048576);

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } stereo_out_t;

  typedef struct packed {
    pos_t    step;
    sample_t left;
    sample_t right;
    logic    known;
    sample_t want_left;
    sample_t want_right;
  } dir_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t left_in = '0;
  sample_t right_in = '0;
  logic    cfg_we = 1'b0;
  pos_t    cfg_wdata = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t left_out;
  sample_t right_out;
  logic    last_of_run;

  stereo_out_t resampled_q[$];
  sample_t     hist [WD][CH];
  pos_t        read_pos;
  pos_t        step_ratio;
  int          held;

  int  bad_fields = 0;
  int  frames_fed = 0;
  int  frames_out = 0;
  int  step_writes = 0;
  int  cycles = 0;
  bit  gapless = 1'b0;

  dir_row_t rows_dir [N_DIRECTED];

  always #5 clk_i = ~clk_i;

  stereo_hermite_resampler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .left_sample_i  (left_in),
    .right_sample_i (right_in),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .left_out_o     (left_out),
    .right_out_o    (right_out),
    .last_of_run_o  (last_of_run)
  );

  // round to nearest, ties toward plus infinity
  function automatic longint round_down(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic sample_t hermite_point(longint x0, longint x1, longint x2, longint x3,
                                            longint t);
    longint c1, c2, c3, a, y;
    c1 = x2 - x0;
    c2 = 2 * x0 - 5 * x1 + 4 * x2 - x3;
    c3 = x3 - x0 + 3 * (x1 - x2);
    a  = round_down(c3 * t, FW) + c2;
    a  = round_down(a * t, FW) + c1;
    a  = round_down(a * t, FW);
    y  = x1 + round_down(a, 1);
    if (y > 32767) begin
      y = 32767;
    end else if (y < -32768) begin
      y = -32768;
    end
    return sample_t'(y);
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < WD; i++) begin
      for (int c = 0; c < CH; c++) begin
        hist[i][c] = '0;
      end
    end
    read_pos   = ONE_POS;
    step_ratio = ONE_POS;
    held       = 1;
  endfunction

  function automatic int resample_frame(sample_t l, sample_t r);
    int          n;
    longint      t;
    logic [PW:0] sum;
    pos_t        next_pos;
    stereo_out_t o;
    n = 0;
    if (held < WD) begin
      hist[held][CH_L] = l;
      hist[held][CH_R] = r;
      held++;
      if (held < WD) begin
        return 0;
      end
    end else begin
      for (int i = 0; i < WD - 1; i++) begin
        hist[i] = hist[i + 1];
      end
      hist[WD - 1][CH_L] = l;
      hist[WD - 1][CH_R] = r;
      read_pos = (read_pos >= ONE_POS) ? read_pos - ONE_POS : '0;
    end
    while (n < MAXO && (read_pos >> FW) == 1) begin
      t = longint'(read_pos[FW-1:0]);
      o.left  = hermite_point(hist[0][CH_L], hist[1][CH_L], hist[2][CH_L], hist[3][CH_L], t);
      o.right = hermite_point(hist[0][CH_R], hist[1][CH_R], hist[2][CH_R], hist[3][CH_R], t);
      sum = {1'b0, read_pos} + {1'b0, step_ratio};
      next_pos = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[PW-1:0];
      o.last = (n + 1 == MAXO) || ((next_pos >> FW) != 1);
      resampled_q.push_back(o);
      read_pos = next_pos;
      n++;
    end
    return n;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gapless || r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t next_sample(sample_t prev);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return sample_t'($urandom);
    end
    if (sel < 6) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    return prev + sample_t'($urandom_range(0, 2047)) - sample_t'(1024);
  endfunction

  task automatic send_frame(sample_t l, sample_t r, output int n);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk_i); while (!in_ready);
    n = resample_frame(l, r);
    frames_fed++;
  endtask

  task automatic drain();
    @(negedge clk_i) in_valid <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_step(pos_t value);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i) cfg_we <= 1'b0;
    step_ratio = value;
    step_writes++;
  endtask

  // receiver stalls
  initial begin
    int unsigned burst, gap;
    forever begin
      burst = gapless ? 64 : $urandom_range(1, 20);
      repeat (burst) @(negedge clk_i) out_ready <= 1'b1;
      gap = pick_gap();
      repeat (gap) @(negedge clk_i) out_ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_out
    stereo_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      frames_out++;
      if (resampled_q.size() == 0) begin
        $error("unexpected item: left_out %0d right_out %0d", left_out, right_out);
        bad_fields++;
      end else begin
        want = resampled_q.pop_front();
        if (left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, left_out);
          bad_fields++;
        end
        if (right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, right_out);
          bad_fields++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          bad_fields++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d items still due", cycles, resampled_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          n;
    pos_t        phase_step [N_PHASES];
    int          phase_len [N_PHASES];
    sample_t     l, r;
    stereo_out_t typed;

    // at step 1.0 each frame after the fill returns the frame two items back
    rows_dir = '{
      '{ONE_POS, 32767, -32768, 1'b0, 0, 0},
      '{ONE_POS, -32768, 32767, 1'b0, 0, 0},
      '{ONE_POS, 0, -1, 1'b1, 32767, -32768},
      '{ONE_POS, -1, 0, 1'b1, -32768, 32767},
      '{ONE_POS, 21845, -21846, 1'b1, 0, -1},
      '{ONE_POS, -21846, 21845, 1'b1, -1, 0},
      '{ONE_POS, 32767, 32767, 1'b1, 21845, -21846},
      '{ONE_POS, -32768, -32768, 1'b1, -21846, 21845},
      '{ONE_POS, 1, -2, 1'b1, 32767, 32767},
      '{ONE_POS, 256, -256, 1'b1, -32768, -32768},
      '{ONE_POS, 12345, -12345, 1'b1, 1, -2},
      '{ONE_POS, -30000, 30000, 1'b1, 256, -256},
      '{HALF_STEP, -32768, 32767, 1'b0, 0, 0},
      '{HALF_STEP, 32767, -32768, 1'b0, 0, 0},
      '{HALF_STEP, 32767, -32768, 1'b0, 0, 0},
      '{HALF_STEP, -32768, 32767, 1'b0, 0, 0},
      '{HALF_STEP, -32768, 32767, 1'b0, 0, 0},
      '{HALF_STEP, 32767, -32768, 1'b0, 0, 0},
      '{HALF_STEP, 32767, -32768, 1'b0, 0, 0},
      '{HALF_STEP, -32768, 32767, 1'b0, 0, 0}
    };

    reset_predictor();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    set_step(ONE_POS);
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (rows_dir[i].step != step_ratio) begin
        set_step(rows_dir[i].step);
      end
      send_frame(rows_dir[i].left, rows_dir[i].right, n);
      if (rows_dir[i].known) begin
        void'(resampled_q.pop_back());
        typed.left  = rows_dir[i].want_left;
        typed.right = rows_dir[i].want_right;
        typed.last  = 1'b1;
        resampled_q.push_back(typed);
      end
    end

    // zero step comes last: the position drops below the window and stays there
    phase_step = '{ONE_POS, MIN_STEP, MAX_STEP, POS_MAX, '0, '0, '0, '0, ONE_POS, '0};
    phase_len  = '{70, 30, 70, 60, 50, 50, 50, 50, 10, 6};
    for (int p = 4; p < 8; p++) begin
      phase_step[p] = (p % 2 == 0) ? pos_t'($urandom_range(2048, 65535))
                                   : pos_t'($urandom_range(65536, 1048576));
    end

    l = '0;
    r = '0;
    for (int p = 0; p < N_PHASES; p++) begin
      set_step(phase_step[p]);
      gapless = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len[p]; k++) begin
        l = next_sample(l);
        r = next_sample(r);
        send_frame(l, r, n);
      end
    end
    gapless = 1'b0;
    drain();

    $display("%0d frames fed under %0d step settings, including saturation and overflow",
             frames_fed, step_writes);
    $display("%0d interpolated items checked, %0d field mismatches", frames_out, bad_fields);
    if (bad_fields == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
